### rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque core
// Request codes, cell command encoding and sizing of the cell chain.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int DATA_W      = 32;
   localparam int CAP_W       = 7;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int WIDE_W      = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int OP_W        = 3;

   localparam logic [DATA_W-1:0] EMPTY_MARK = '1;
   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(MAX_ENTRIES);

   // request codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_QUERY      = 3'd4
   } req_op_type;

   // per-cycle command broadcast to every cell of a chain
   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_INSERT = 3'd1,   // shift toward tail, new value enters at cell 0
      CELL_APPEND = 3'd2,   // first empty cell takes the new value
      CELL_REMOVE = 3'd3,   // shift toward head, cell 0 drops out
      CELL_DROP   = 3'd4,   // last occupied cell goes empty
      CELL_CLEAR  = 3'd5    // every cell goes empty
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

### rtl/core/cdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell: one entry of the deque chain
// Holds a value and an occupied bit; trades data with both neighbors.
// ----------------------------------------------------------------------------
module cdq_cell import cdq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_cmd_type      cmd,
   input  logic [DATA_W-1:0] left_data,
   input  logic              left_valid,
   input  logic [DATA_W-1:0] right_data,
   input  logic              right_valid,
   output logic [DATA_W-1:0] data,
   output logic              valid
);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (cmd.op)
         CELL_INSERT: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         CELL_APPEND: begin
            if (!valid_ff && left_valid) begin
               data_in  = cmd.value;
               valid_in = 1'b1;
            end
         end
         CELL_REMOVE: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         CELL_DROP: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            data_in  = data_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

### rtl/core/cdq_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_chain: row of deque cells, cell 0 at the head end
// Cell 0 sees the command value as its left neighbor; the last cell sees empty.
// ----------------------------------------------------------------------------
module cdq_chain import cdq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_cmd_type      cmd,
   output logic [DATA_W-1:0] head_data,
   output logic              head_valid
);

   logic [DATA_W-1:0] cell_data  [MAX_ENTRIES];
   logic              cell_valid [MAX_ENTRIES];

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [DATA_W-1:0] l_data, r_data;
      logic              l_valid, r_valid;

      if (i == 0) begin : g_first
         assign l_data  = cmd.value;
         assign l_valid = 1'b1;
      end else begin : g_mid_l
         assign l_data  = cell_data[i-1];
         assign l_valid = cell_valid[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_last
         assign r_data  = '0;
         assign r_valid = 1'b0;
      end else begin : g_mid_r
         assign r_data  = cell_data[i+1];
         assign r_valid = cell_valid[i+1];
      end

      cdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_data   (l_data),
         .left_valid  (l_valid),
         .right_data  (r_data),
         .right_valid (r_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i])
      );
   end

   assign head_data  = cell_data[0];
   assign head_valid = cell_valid[0];

endmodule

### rtl/core/circular_deque_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_core: double-ended queue with a programmable capacity
// Two mirrored cell chains hold the entries; one serves the front, one the rear.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_type / req_data_value with start high; the request is
//     taken at any edge where busy is low. One request per cycle is accepted.
//   Response: rsp_valid pulses in the cycle after each accepted request, with
//     success, front and rear values (all ones when empty) and empty/full
//     flags as they stand after that request. The receiver cannot hold off.
//   Throughput is one request per cycle while busy is low; the cell chains
//     update every entry in parallel so no request waits on another.
//   Capacity: written through csr_valid/csr_ready while no request is in
//     flight; a write empties the deque. 0 acts as 1, above 64 acts as 64.
//   Reset: synchronous; deque empty, capacity 64, busy held high until the
//     first edge after reset is released.
// ----------------------------------------------------------------------------
module circular_deque_core import cdq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_type,
   input  logic signed [DATA_W-1:0] req_data_value,
   // response channel
   output logic                     rsp_valid,
   output logic                     rsp_success,
   output logic signed [DATA_W-1:0] rsp_front_value,
   output logic signed [DATA_W-1:0] rsp_rear_value,
   output logic                     rsp_empty_flag,
   output logic                     rsp_full_flag,
   // capacity register
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_W-1:0]         csr_capacity
);

   logic             busy_ff;
   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   logic             success_ff, success_in;

   logic             accept;
   logic             csr_write;
   logic [CNT_W-1:0] eff_cap;
   req_op_type       op;
   logic             is_push, is_pop;

   cell_cmd_type     front_cmd, rear_cmd;
   logic [DATA_W-1:0] front_data, rear_data;
   logic              front_valid, rear_valid;

   assign accept    = start && !busy_ff;
   assign csr_write = csr_valid && csr_ready;
   assign op        = req_op_type'(req_type);

   // capacity as used: clamp to 1..MAX_ENTRIES
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (WIDE_W'(cap_ff) > WIDE_W'(MAX_ENTRIES)) begin
         eff_cap = CNT_W'(MAX_ENTRIES);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign is_push = req_type inside {OP_PUSH_FRONT, OP_PUSH_BACK};
   assign is_pop  = req_type inside {OP_POP_FRONT, OP_POP_BACK};

   // Decode: the front chain keeps entries front-first, the rear chain keeps
   // them rear-first, so each end is always at cell 0 of its own chain.
   always_comb begin
      front_cmd.op    = CELL_HOLD;
      rear_cmd.op     = CELL_HOLD;
      front_cmd.value = req_data_value;
      rear_cmd.value  = req_data_value;
      success_in      = 1'b0;
      count_in        = count_ff;

      if (csr_write) begin
         front_cmd.op = CELL_CLEAR;
         rear_cmd.op  = CELL_CLEAR;
         count_in     = '0;
      end else if (accept) begin
         if (is_push && (count_ff < eff_cap)) begin
            success_in = 1'b1;
            count_in   = count_ff + CNT_W'(1);
         end else if (is_pop && (count_ff != '0)) begin
            success_in = 1'b1;
            count_in   = count_ff - CNT_W'(1);
         end

         case (op)
            OP_PUSH_FRONT: begin
               if (success_in) begin
                  front_cmd.op = CELL_INSERT;
                  rear_cmd.op  = CELL_APPEND;
               end
            end
            OP_PUSH_BACK: begin
               if (success_in) begin
                  front_cmd.op = CELL_APPEND;
                  rear_cmd.op  = CELL_INSERT;
               end
            end
            OP_POP_FRONT: begin
               if (success_in) begin
                  front_cmd.op = CELL_REMOVE;
                  rear_cmd.op  = CELL_DROP;
               end
            end
            OP_POP_BACK: begin
               if (success_in) begin
                  front_cmd.op = CELL_DROP;
                  rear_cmd.op  = CELL_REMOVE;
               end
            end
            OP_QUERY: begin
               success_in = 1'b1;
            end
            default: begin
               success_in = 1'b0;   // unknown code, state untouched
            end
         endcase
      end
   end

   cdq_chain u_front_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (front_cmd),
      .head_data  (front_data),
      .head_valid (front_valid)
   );

   cdq_chain u_rear_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (rear_cmd),
      .head_data  (rear_data),
      .head_valid (rear_valid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         success_ff   <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         success_ff   <= success_in;
         if (csr_write) begin
            cap_ff <= csr_capacity;
         end
      end
   end

   // response reads the chain heads after the update
   assign busy            = busy_ff;
   assign csr_ready       = !busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = success_ff;
   assign rsp_front_value = front_valid ? front_data : EMPTY_MARK;
   assign rsp_rear_value  = rear_valid ? rear_data : EMPTY_MARK;
   assign rsp_empty_flag  = (count_ff == '0);
   assign rsp_full_flag   = (count_ff == eff_cap);

`ifndef SYNTHESIS
   a_front_head: assert property (@(posedge clock) disable iff (reset)
      front_valid == (count_ff != '0))
      else $error("front chain head disagrees with entry count");

   a_rear_head: assert property (@(posedge clock) disable iff (reset)
      rear_valid == (count_ff != '0))
      else $error("rear chain head disagrees with entry count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> (count_ff <= eff_cap))
      else $error("entry count above capacity");

   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_write && !success_in |=> $stable(count_ff))
      else $error("failed request changed the entry count");

   a_rsp_follow: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");
`endif

endmodule
